FILE: rtl/core/fprc_pkg.sv
// Package for the framed packet receiver with CRC-16 check.
// Holds the word types, field codes, register reset values and the CRC helper.
// Used by fprc_result_queue and framed_packet_receiver_crc_check_top.
package fprc_pkg;

    // Default for the largest payload a frame may carry.
    localparam int MAX_PAYLOAD_DEF = 256;

    // Depth of the result queue in front of the output channel.
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // CRC-16 polynomial and top bit, MSB first.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Register reset values.
    localparam logic [7:0]  START_BYTE_RST    = 8'd90;
    localparam logic [7:0]  EXPECTED_TYPE_RST = 8'd165;
    localparam logic [7:0]  MAX_RETRIES_RST   = 8'd3;
    localparam logic [15:0] TIMEOUT_MS_RST    = 16'd1000;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_START_BYTE    = 2'd0;
    localparam logic [1:0] REG_EXPECTED_TYPE = 2'd1;
    localparam logic [1:0] REG_MAX_RETRIES   = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_MS    = 2'd3;

    // Input word operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result word kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CRC_RETRY  = 3'd1;
    localparam logic [2:0] ST_WRONG_TYPE = 3'd2;
    localparam logic [2:0] ST_TIMEOUT    = 3'd3;
    localparam logic [2:0] ST_RETRY_FAIL = 3'd4;

    // Reply codes.
    localparam logic [1:0] REPLY_NONE = 2'd0;
    localparam logic [1:0] REPLY_ACK  = 2'd1;
    localparam logic [1:0] REPLY_NAK  = 2'd2;

    // Receiver phases.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_PAYLOAD
    } phase_t;

    // One input word.
    typedef struct packed {
        logic       op;
        logic [7:0] data_in;
    } rx_word_t;

    // One result word.
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [2:0] status;
        logic [1:0] reply;
        logic [8:0] payload_length;
        logic       last;
    } res_word_t;

    // Results produced by one input word, handed to the queue.
    typedef struct packed {
        logic [1:0] count;
        res_word_t  first;
        res_word_t  second;
    } res_push_t;

    // Bytewise CRC-16 update, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/fprc_result_queue.sv
// Result queue of the framed packet receiver: a short shift queue that takes
// up to two result words per cycle and presents its head on the output channel.
// Depends on fprc_pkg.
module fprc_result_queue
    import fprc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t push,
    output logic      room,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res_word
);

    res_word_t             entry_reg  [QUEUE_DEPTH];
    res_word_t             entry_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;
    logic [QCNT_W-1:0]     base;
    logic                  pop;

    // Head of the queue is the output word.
    assign res_valid = (count_reg != '0);
    assign res_word  = entry_reg[0];
    assign pop       = res_valid && !res_stall;

    // Room for the worst case of two results from one input word.
    assign room = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

    // Shift out on a pop, then append new results after the survivors.
    always_comb
    begin
        base = count_reg - QCNT_W'(pop);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && (i < QUEUE_DEPTH - 1))
                entry_next[i] = entry_reg[(i + 1) % QUEUE_DEPTH];
            else
                entry_next[i] = entry_reg[i];
            if ((push.count != 2'd0) && (QCNT_W'(i) == base))
                entry_next[i] = push.first;
            if ((push.count == 2'd2) && (QCNT_W'(i) == base + QCNT_W'(1)))
                entry_next[i] = push.second;
        end
        count_next = base + QCNT_W'(push.count);
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // Entry payload needs no reset.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            entry_reg[i] <= entry_next[i];
    end

endmodule

FILE: rtl/core/framed_packet_receiver_crc_check_top.sv
// Top level of the framed packet receiver with CRC-16 check: configuration
// registers, the frame state machine and the result queue.
// Depends on fprc_pkg and fprc_result_queue.
//
//   Channel | Direction | Handshake               | Word
//   --------+-----------+-------------------------+--------------------------
//   rx      | in        | rx_valid / rx_stall     | rx_word  (op, data_in)
//   res     | out       | res_valid / res_stall   | res_word (verdict/payload)
//   apb     | in        | psel, penable, pready   | paddr, pwdata, prdata
//
// Each input word is handled in the cycle it is accepted; the result words it
// yields, if any, are registered into the result queue. One input word is
// taken every cycle while the four-entry result queue holds two or fewer
// words, so rx_stall rises only when the output side stalls. A final payload
// byte yields two result words, delivered in order as the output takes them.
// Reset clears the phase, counters and queue and loads the register defaults.
module framed_packet_receiver_crc_check_top
    import fprc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  rx_word_t    rx_word,
    output logic        res_valid,
    input  logic        res_stall,
    output res_word_t   res_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    // Configuration registers.
    logic [7:0]  start_byte_reg;
    logic [7:0]  expected_type_reg;
    logic [7:0]  max_retries_reg;
    logic [15:0] timeout_ms_reg;
    logic [15:0] start_crc_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    // Frame state.
    phase_t           phase_reg, phase_next;
    logic [15:0]      crc_reg, crc_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [15:0]      rcrc_reg, rcrc_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       retries_reg, retries_next;
    logic [16:0]      ticks_reg, ticks_next;

    // Working signals.
    logic             rx_accept;
    logic             room;
    res_push_t        push;
    logic [15:0]      len16;
    logic [15:0]      cnt16;
    logic [16:0]      raw_len;
    logic [16:0]      clamp_len;
    logic [16:0]      ticks_inc;
    logic [LEN_W:0]   cnt_inc;
    logic [15:0]      crc_byte_new;
    logic             do_verdict;
    logic             verdict_second;
    logic [15:0]      verdict_crc;
    logic             end_transaction;
    res_word_t        verdict_word;

    assign rx_accept = rx_valid && !rx_stall;
    assign rx_stall  = !room;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    // Configuration registers; the CRC of the start byte is kept alongside.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_byte_reg    <= START_BYTE_RST;
            start_crc_reg     <= crc16_byte(16'h0000, START_BYTE_RST);
            expected_type_reg <= EXPECTED_TYPE_RST;
            max_retries_reg   <= MAX_RETRIES_RST;
            timeout_ms_reg    <= TIMEOUT_MS_RST;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_START_BYTE:
                begin
                    start_byte_reg <= pwdata[7:0];
                    start_crc_reg  <= crc16_byte(16'h0000, pwdata[7:0]);
                end
                REG_EXPECTED_TYPE: expected_type_reg <= pwdata[7:0];
                REG_MAX_RETRIES:   max_retries_reg   <= pwdata[7:0];
                REG_TIMEOUT_MS:    timeout_ms_reg    <= pwdata[15:0];
                default:           start_byte_reg    <= start_byte_reg;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        case (cfg_index)
            REG_START_BYTE:    prdata = {24'h0, start_byte_reg};
            REG_EXPECTED_TYPE: prdata = {24'h0, expected_type_reg};
            REG_MAX_RETRIES:   prdata = {24'h0, max_retries_reg};
            REG_TIMEOUT_MS:    prdata = {16'h0, timeout_ms_reg};
            default:           prdata = 32'h0;
        endcase
    end

    assign len16        = 16'(len_reg);
    assign cnt16        = 16'(cnt_reg);
    assign raw_len      = {1'b0, rx_word.data_in, len_lo_reg};
    assign clamp_len    = (raw_len < 17'(MAX_PAYLOAD)) ? raw_len : 17'(MAX_PAYLOAD);
    assign ticks_inc    = ticks_reg + 17'd1;
    assign cnt_inc      = {1'b0, cnt_reg} + (LEN_W + 1)'(1);
    assign crc_byte_new = crc16_byte(crc_reg, rx_word.data_in);

    // Frame state machine: next state and result words.
    always_comb
    begin
        phase_next      = phase_reg;
        crc_next        = crc_reg;
        len_next        = len_reg;
        len_lo_next     = len_lo_reg;
        rcrc_next       = rcrc_reg;
        cnt_next        = cnt_reg;
        retries_next    = retries_reg;
        ticks_next      = ticks_reg;
        push            = '0;
        do_verdict      = 1'b0;
        verdict_second  = 1'b0;
        verdict_crc     = crc_reg;
        end_transaction = 1'b0;
        verdict_word    = '0;

        if (rx_accept) begin
            if (rx_word.op == OP_TICK) begin
                // Ticks count only while hunting.
                if (phase_reg == PH_HUNT) begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= {1'b0, timeout_ms_reg} + 17'd1) begin
                        push.count       = 2'd1;
                        push.first.kind  = KIND_VERDICT;
                        push.first.status = ST_TIMEOUT;
                        push.first.reply = REPLY_NONE;
                        push.first.last  = 1'b1;
                        end_transaction  = 1'b1;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_word.data_in == start_byte_reg)
                            phase_next = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        if (rx_word.data_in != expected_type_reg) begin
                            push.count        = 2'd1;
                            push.first.kind   = KIND_VERDICT;
                            push.first.status = ST_WRONG_TYPE;
                            push.first.reply  = REPLY_NONE;
                            push.first.last   = 1'b1;
                            end_transaction   = 1'b1;
                        end else begin
                            crc_next   = crc16_byte(start_crc_reg, rx_word.data_in);
                            phase_next = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO:
                    begin
                        len_lo_next = rx_word.data_in;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        // Clamp the length and run it through the CRC, low byte first.
                        len_next   = LEN_W'(clamp_len);
                        crc_next   = crc16_byte(crc16_byte(crc_reg, clamp_len[7:0]),
                                                clamp_len[15:8]);
                        phase_next = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        rcrc_next  = {8'h00, rx_word.data_in};
                        phase_next = PH_CRC_HI;
                    end
                    PH_CRC_HI:
                    begin
                        rcrc_next = {rx_word.data_in, rcrc_reg[7:0]};
                        cnt_next  = '0;
                        if (len_reg == '0) begin
                            do_verdict  = 1'b1;
                            verdict_crc = crc_reg;
                        end else begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        crc_next                  = crc_byte_new;
                        cnt_next                  = LEN_W'(cnt_inc);
                        push.count                = 2'd1;
                        push.first.kind           = KIND_PAYLOAD;
                        push.first.data_byte      = rx_word.data_in;
                        push.first.byte_index     = cnt16[7:0];
                        push.first.payload_length = len16[8:0];
                        if (cnt_inc >= {1'b0, len_reg}) begin
                            do_verdict     = 1'b1;
                            verdict_second = 1'b1;
                            verdict_crc    = crc_byte_new;
                        end else begin
                            push.first.last = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end

        // CRC verdict: ACK on a match, NAK with retry or final failure otherwise.
        if (do_verdict) begin
            verdict_word.kind           = KIND_VERDICT;
            verdict_word.payload_length = len16[8:0];
            verdict_word.last           = 1'b1;
            if (verdict_crc == rcrc_next) begin
                verdict_word.status = ST_OK;
                verdict_word.reply  = REPLY_ACK;
                end_transaction     = 1'b1;
            end else if (retries_reg <= 8'd1) begin
                verdict_word.status = ST_RETRY_FAIL;
                verdict_word.reply  = REPLY_NAK;
                end_transaction     = 1'b1;
            end else begin
                verdict_word.status = ST_CRC_RETRY;
                verdict_word.reply  = REPLY_NAK;
                retries_next        = retries_reg - 8'd1;
            end
            phase_next = PH_HUNT;
            ticks_next = '0;
            if (verdict_second) begin
                push.count  = 2'd2;
                push.second = verdict_word;
            end else begin
                push.count = 2'd1;
                push.first = verdict_word;
            end
        end

        // Closing a transaction restarts the hunt with a full retry budget.
        if (end_transaction) begin
            phase_next   = PH_HUNT;
            ticks_next   = '0;
            retries_next = max_retries_reg;
        end

        // A new retry limit reloads the budget.
        if (cfg_write && (cfg_index == REG_MAX_RETRIES))
            retries_next = pwdata[7:0];
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= '0;
            len_reg     <= '0;
            len_lo_reg  <= '0;
            rcrc_reg    <= '0;
            cnt_reg     <= '0;
            retries_reg <= MAX_RETRIES_RST;
            ticks_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            len_reg     <= len_next;
            len_lo_reg  <= len_lo_next;
            rcrc_reg    <= rcrc_next;
            cnt_reg     <= cnt_next;
            retries_reg <= retries_next;
            ticks_reg   <= ticks_next;
        end
    end

    // Result queue in front of the output channel.
    fprc_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

endmodule

FILE: tb/tb_framed_packet_receiver_crc_check_top.sv
// Self-checking testbench for framed_packet_receiver_crc_check_top.
// It drives framed byte streams and ticks with random idling on both sides and
// checks every result word against a built-in predictor. Depends on fprc_pkg.
module tb_framed_packet_receiver_crc_check_top;
    import fprc_pkg::*;

    // Clock, reset and block ports.
    logic        clk       = 1'b0;
    logic        rst_n;
    logic        rx_valid  = 1'b0;
    logic        rx_stall;
    rx_word_t    rx_word   = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    res_word_t   res_word;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    // Register mirror.
    logic [7:0]  cfg_start   = START_BYTE_RST;
    logic [7:0]  cfg_type    = EXPECTED_TYPE_RST;
    logic [7:0]  cfg_retries = MAX_RETRIES_RST;
    logic [15:0] cfg_timeout = TIMEOUT_MS_RST;

    // Frame state of the predictor.
    phase_t      rx_phase     = PH_HUNT;
    logic [15:0] crc_acc      = '0;
    logic [15:0] frame_len    = '0;
    logic [15:0] frame_crc    = '0;
    logic [15:0] pay_count    = '0;
    logic [7:0]  retries_left = MAX_RETRIES_RST;
    logic [16:0] hunt_ticks   = '0;

    // Words waiting to be sent and result words still to come.
    rx_word_t    rx_pending[$];
    res_word_t   exp_results[$];

    int          words_queued = 0;
    int          err_count    = 0;
    int          results_seen = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          hold_left    = 0;
    bit          sender_calm  = 1'b0;
    bit          recv_calm    = 1'b0;

    framed_packet_receiver_crc_check_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_word   (rx_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The falling edge of reset at time zero is what starts the block's reset.
    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Watchdog for a hung run.
    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Bytewise CRC-16 update, polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {b, 8'h00};
        repeat (8)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic res_word_t make_result(input logic kind, input logic [7:0] data,
                                              input logic [7:0] idx, input logic [2:0] status,
                                              input logic [1:0] reply, input logic [8:0] len,
                                              input logic last);
        res_word_t r;
        r.kind           = kind;
        r.data_byte      = data;
        r.byte_index     = idx;
        r.status         = status;
        r.reply          = reply;
        r.payload_length = len;
        r.last           = last;
        return r;
    endfunction

    // Hunting restarts the tick count; a finished transaction reloads the budget.
    task automatic start_hunt(input bit end_transaction);
        rx_phase   = PH_HUNT;
        hunt_ticks = '0;
        if (end_transaction)
            retries_left = cfg_retries;
    endtask

    // Verdict at the end of a frame: ACK, NAK with retry, or retry failure.
    task automatic crc_verdict();
        if (crc_acc == frame_crc)
        begin
            exp_results.push_back(make_result(KIND_VERDICT, 8'h00, 8'h00, ST_OK, REPLY_ACK,
                                              frame_len[8:0], 1'b1));
            start_hunt(1'b1);
        end
        else if (retries_left <= 8'd1)
        begin
            exp_results.push_back(make_result(KIND_VERDICT, 8'h00, 8'h00, ST_RETRY_FAIL,
                                              REPLY_NAK, frame_len[8:0], 1'b1));
            start_hunt(1'b1);
        end
        else
        begin
            retries_left = retries_left - 8'd1;
            exp_results.push_back(make_result(KIND_VERDICT, 8'h00, 8'h00, ST_CRC_RETRY,
                                              REPLY_NAK, frame_len[8:0], 1'b1));
            start_hunt(1'b0);
        end
    endtask

    // Works out the result words caused by one accepted input word.
    task automatic predict_rx(input rx_word_t w);
        int unsigned raw;
        if (w.op == OP_TICK)
        begin
            // Ticks count only while hunting.
            if (rx_phase == PH_HUNT)
            begin
                hunt_ticks = hunt_ticks + 17'd1;
                if (hunt_ticks >= cfg_timeout + 1)
                begin
                    exp_results.push_back(make_result(KIND_VERDICT, 8'h00, 8'h00, ST_TIMEOUT,
                                                      REPLY_NONE, 9'd0, 1'b1));
                    start_hunt(1'b1);
                end
            end
        end
        else
        begin
            case (rx_phase)
                PH_HUNT:
                begin
                    if (w.data_in == cfg_start)
                        rx_phase = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (w.data_in != cfg_type)
                    begin
                        exp_results.push_back(make_result(KIND_VERDICT, 8'h00, 8'h00,
                                                          ST_WRONG_TYPE, REPLY_NONE, 9'd0,
                                                          1'b1));
                        start_hunt(1'b1);
                    end
                    else
                    begin
                        crc_acc  = crc_step(crc_step(16'h0000, cfg_start), w.data_in);
                        rx_phase = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    frame_len = {8'h00, w.data_in};
                    rx_phase  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    raw       = {w.data_in, frame_len[7:0]};
                    frame_len = (raw < MAX_PAYLOAD_DEF) ? 16'(raw) : 16'(MAX_PAYLOAD_DEF);
                    crc_acc   = crc_step(crc_step(crc_acc, frame_len[7:0]), frame_len[15:8]);
                    rx_phase  = PH_CRC_LO;
                end
                PH_CRC_LO:
                begin
                    frame_crc = {8'h00, w.data_in};
                    rx_phase  = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    frame_crc[15:8] = w.data_in;
                    pay_count       = '0;
                    if (frame_len == 16'd0)
                        crc_verdict();
                    else
                        rx_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    // The final payload byte is followed by the verdict word.
                    crc_acc   = crc_step(crc_acc, w.data_in);
                    pay_count = pay_count + 16'd1;
                    if (pay_count >= frame_len)
                    begin
                        exp_results.push_back(make_result(KIND_PAYLOAD, w.data_in,
                                                          8'(pay_count - 16'd1), ST_OK,
                                                          REPLY_NONE, frame_len[8:0], 1'b0));
                        crc_verdict();
                    end
                    else
                    begin
                        exp_results.push_back(make_result(KIND_PAYLOAD, w.data_in,
                                                          8'(pay_count - 16'd1), ST_OK,
                                                          REPLY_NONE, frame_len[8:0], 1'b1));
                    end
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Idle cycles before the next word; mostly none, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_calm || r < 70)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Input driver: feeds the pending words and predicts each accepted word.
    always @(posedge clk)
    begin : rx_driver
        logic     nxt_valid;
        rx_word_t nxt_word;
        if (rx_valid && !rx_stall)
            predict_rx(rx_word);
        nxt_valid = rx_valid;
        nxt_word  = rx_word;
        if (!rx_valid || !rx_stall)
        begin
            if (gap_left > 0)
            begin
                nxt_valid = 1'b0;
                gap_left  = gap_left - 1;
            end
            else if (rx_pending.size() > 0)
            begin
                nxt_word  = rx_pending.pop_front();
                nxt_valid = 1'b1;
                gap_left  = pick_gap();
            end
            else
            begin
                nxt_valid = 1'b0;
            end
        end
        rx_valid <= nxt_valid;
        rx_word  <= nxt_word;
    end

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", fname, want, got);
            err_count++;
        end
    endtask

    // Output monitor and stall generator, with two long hold-offs.
    always @(posedge clk)
    begin : res_monitor
        res_word_t want;
        logic      nxt_stall;
        if (res_valid && !res_stall)
        begin
            if (exp_results.size() == 0)
            begin
                $error("result word with nothing expected: kind %0d data_byte %0d status %0d",
                       res_word.kind, res_word.data_byte, res_word.status);
                err_count++;
            end
            else
            begin
                want = exp_results.pop_front();
                check_field("kind", want.kind, res_word.kind);
                check_field("data_byte", want.data_byte, res_word.data_byte);
                check_field("byte_index", want.byte_index, res_word.byte_index);
                check_field("status", want.status, res_word.status);
                check_field("reply", want.reply, res_word.reply);
                check_field("payload_length", want.payload_length, res_word.payload_length);
                check_field("last", want.last, res_word.last);
            end
            results_seen++;
            if (results_seen == 60 || results_seen == 700)
                hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            nxt_stall = 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            nxt_stall  = 1'b1;
        end
        else if (!recv_calm && $urandom_range(0, 3) == 0)
        begin
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                       : $urandom_range(9, 39);
            nxt_stall  = 1'b1;
        end
        else
        begin
            nxt_stall = 1'b0;
        end
        res_stall <= nxt_stall;
    end

    task automatic send_word(input logic op, input logic [7:0] data);
        rx_word_t w;
        w.op      = op;
        w.data_in = data;
        rx_pending.push_back(w);
        words_queued++;
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_word(OP_BYTE, data);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Queues a whole frame with a correct or corrupted CRC.
    task automatic send_frame(input logic [7:0] ftype, input int unsigned raw_len,
                              input bit bad_crc, input bit alt_fill, input bit tick_inside);
        int unsigned clen;
        int          i;
        logic [15:0] crc;
        logic [15:0] len16;
        logic [7:0]  b;
        logic [7:0]  body[$];
        clen  = (raw_len < MAX_PAYLOAD_DEF) ? raw_len : MAX_PAYLOAD_DEF;
        len16 = 16'(raw_len);
        crc   = crc_step(crc_step(16'h0000, cfg_start), ftype);
        crc   = crc_step(crc_step(crc, clen[7:0]), clen[15:8]);
        for (i = 0; i < clen; i++)
        begin
            b = alt_fill ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
            body.push_back(b);
            crc = crc_step(crc, b);
        end
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(1, 65535));
        send_byte(cfg_start);
        send_byte(ftype);
        if (tick_inside)
            send_tick();
        send_byte(len16[7:0]);
        send_byte(len16[15:8]);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[j])
            send_byte(body[j]);
    endtask

    // Random traffic: mostly well-formed frames, the rest ticks, noise and
    // broken frames.
    task automatic send_traffic(input int n);
        int          target;
        int          r;
        int          k;
        int unsigned plen;
        logic [7:0]  t;
        target = words_queued + n;
        while (words_queued < target)
        begin
            r    = $urandom_range(0, 99);
            plen = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            if (r < 62)
                send_frame(cfg_type, plen, 1'b0, 1'b0, $urandom_range(0, 19) == 0);
            else if (r < 74)
                send_frame(cfg_type, plen, 1'b1, 1'b0, 1'b0);
            else if (r < 80)
            begin
                do
                    t = 8'($urandom_range(0, 255));
                while (t == cfg_type);
                send_byte(cfg_start);
                send_byte(t);
            end
            else if (r < 88)
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_tick();
            end
            else if (r < 94)
            begin
                k = $urandom_range(1, 4);
                repeat (k) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                // Frame cut off after its type byte and up to three further bytes.
                send_byte(cfg_start);
                send_byte(cfg_type);
                k = $urandom_range(0, 3);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Waits until every word is sent and every result word has arrived.
    task automatic wait_drained();
        while (rx_pending.size() != 0 || rx_valid || exp_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write through the configuration port, mirrored in the predictor.
    task automatic set_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_BYTE:    cfg_start   = value[7:0];
            REG_EXPECTED_TYPE: cfg_type    = value[7:0];
            REG_MAX_RETRIES:
            begin
                cfg_retries  = value[7:0];
                retries_left = value[7:0];
            end
            REG_TIMEOUT_MS:    cfg_timeout = value[15:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic set_all(input logic [7:0] sb, input logic [7:0] ty,
                           input logic [7:0] mr, input logic [15:0] to);
        set_reg(REG_START_BYTE, {24'h0, sb});
        set_reg(REG_EXPECTED_TYPE, {24'h0, ty});
        set_reg(REG_MAX_RETRIES, {24'h0, mr});
        set_reg(REG_TIMEOUT_MS, {16'h0, to});
    endtask

    // Feeds filler bytes until the receiver is hunting again.
    task automatic return_to_hunt();
        while (rx_phase != PH_HUNT)
        begin
            send_byte(8'($urandom_range(0, 255)));
            wait_drained();
        end
    endtask

    initial
    begin : main_seq
        int ph;
        @(posedge rst_n);
        @(posedge clk);

        // Directed words at the reset settings: ignored tick and byte, wrong
        // type, zero-length frames with good and bad CRC, and a short frame
        // of extreme bytes with a tick inside it.
        send_tick();
        send_byte(8'h00);
        send_byte(cfg_start);
        send_byte(~cfg_type);
        send_frame(cfg_type, 0, 1'b0, 1'b0, 1'b0);
        send_frame(cfg_type, 0, 1'b1, 1'b0, 1'b0);
        send_frame(cfg_type, 2, 1'b0, 1'b1, 1'b1);
        wait_drained();

        // Low extremes: every hunting tick times out, one CRC failure ends it.
        set_all(8'h00, 8'hFF, 8'd1, 16'd0);
        return_to_hunt();
        sender_calm <= 1'b1;
        recv_calm   <= 1'b0;
        send_traffic(150);
        wait_drained();

        // High extremes with the largest payloads.
        set_all(8'hFF, 8'h00, 8'd255, 16'hFFFF);
        return_to_hunt();
        sender_calm <= 1'b0;
        recv_calm   <= 1'b1;
        send_frame(cfg_type, 65535, 1'b0, 1'b0, 1'b0);
        send_frame(cfg_type, 256, 1'b1, 1'b0, 1'b0);
        send_traffic(100);
        wait_drained();

        // Random settings with mostly short timeouts and small retry budgets.
        for (ph = 0; ph < 4; ph++)
        begin
            set_all(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(1, 6)),
                    ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 12))
                                               : 16'($urandom_range(13, 65535)));
            return_to_hunt();
            sender_calm <= (ph == 2);
            recv_calm   <= (ph == 1);
            send_traffic(150);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/fprc_pkg.sv
rtl/core/fprc_result_queue.sv
rtl/core/framed_packet_receiver_crc_check_top.sv
tb/tb_framed_packet_receiver_crc_check_top.sv
